FILE: hdl/hvt_pkg.sv
package hvt_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned Dim       = 4;
  localparam int unsigned ProdWidth = 2 * DataWidth;
  localparam int unsigned PairWidth = ProdWidth + 1;
  localparam int unsigned SumWidth  = ProdWidth + 2;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [Dim-1:0][DataWidth-1:0] quad_t;

  typedef struct packed {
    logic en_mul;
    logic en_pair;
    logic en_sum;
  } lane_ctrl_t;

endpackage

FILE: hdl/hvt_lane.sv
module hvt_lane import hvt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  quad_t      row_elems,
  input  quad_t      vec,
  output word_t      dot
);

  logic signed [ProdWidth-1:0] prod [Dim];
  logic signed [PairWidth-1:0] pair [2];
  logic signed [SumWidth-1:0]  total;
  logic signed [SumWidth-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int i = 0; i < Dim; i++) begin
        prod[i] <= $signed(row_elems[i]) * $signed(vec[i]);
      end
    end
    if (ctrl.en_pair) begin
      pair[0] <= PairWidth'(prod[0]) + PairWidth'(prod[1]);
      pair[1] <= PairWidth'(prod[2]) + PairWidth'(prod[3]);
    end
    if (ctrl.en_sum) begin
      total <= SumWidth'(pair[0]) + SumWidth'(pair[1]);
    end
  end

  // clamp to 32 bits after the fixed-point shift
  always_comb begin
    shifted = total >>> FRAC_BITS;
    if ((&shifted[SumWidth-1:DataWidth-1]) || !(|shifted[SumWidth-1:DataWidth-1])) begin
      dot = shifted[DataWidth-1:0];
    end else if (shifted[SumWidth-1]) begin
      dot = {1'b1, {(DataWidth-1){1'b0}}};
    end else begin
      dot = {1'b0, {(DataWidth-1){1'b1}}};
    end
  end

endmodule

FILE: hdl/homogeneous_vertex_transform_core.sv
// A transform beat loads its products at acceptance, then passes through the pair add and final add,
// and is shifted and saturated into the output register.
// Throughput: one beat per cycle while out_ready does not stall it; four row lanes run in parallel.
// Matrix writes take effect the cycle after acceptance and give no output beat.
// Reset (rst, synchronous, active high) clears the matrix and all valid flags.
module homogeneous_vertex_transform_core import hvt_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [1:0]  elem_row,
  input  logic [1:0]  elem_col,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] vec_w,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w
);

  word_t      matrix [Dim*Dim];
  logic       v_mul;
  logic       v_pair;
  logic       v_sum;
  logic       adv_mul;
  logic       adv_pair;
  logic       adv_sum;
  logic       adv_out;
  logic       in_fire;
  lane_ctrl_t ctrl;
  quad_t      vec;
  word_t      dot [Dim];

  assign adv_out  = !out_valid || out_ready;
  assign adv_sum  = !v_sum || adv_out;
  assign adv_pair = !v_pair || adv_sum;
  assign adv_mul  = !v_mul || adv_pair;
  assign in_ready = adv_mul;
  assign in_fire  = in_valid && in_ready;

  assign ctrl.en_mul  = adv_mul;
  assign ctrl.en_pair = adv_pair;
  assign ctrl.en_sum  = adv_sum;

  assign vec = {vec_w, vec_z, vec_y, vec_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Dim*Dim; i++) begin
        matrix[i] <= '0;
      end
    end else if (in_fire && opcode == OP_WRITE) begin
      matrix[{elem_row, elem_col}] <= elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      v_pair    <= 1'b0;
      v_sum     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_mul) begin
        v_mul <= in_valid && opcode == OP_TRANSFORM;
      end
      if (adv_pair) begin
        v_pair <= v_mul;
      end
      if (adv_sum) begin
        v_sum <= v_pair;
      end
      if (adv_out) begin
        out_valid <= v_sum;
      end
    end
  end

  for (genvar r = 0; r < Dim; r++) begin : g_lane
    hvt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .ctrl      (ctrl),
      .row_elems ({matrix[r*Dim+3], matrix[r*Dim+2], matrix[r*Dim+1], matrix[r*Dim]}),
      .vec       (vec),
      .dot       (dot[r])
    );
  end

  // merge the four lanes into one output beat
  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_x <= dot[0];
      out_y <= dot[1];
      out_z <= dot[2];
      out_w <= dot[3];
    end
  end

endmodule

FILE: test/testbench.sv
module testbench;
  import hvt_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 16;
  localparam int RandomItems = 1800;
  localparam int QuietItems = 200;

  localparam word_t QOne  = 32'h0001_0000;
  localparam word_t QMax  = 32'h7FFF_FFFF;
  localparam word_t QMin  = 32'h8000_0000;
  localparam word_t QNeg1 = 32'hFFFF_FFFF;

  class vertex_scoreboard;
    localparam logic signed [65:0] SatHigh = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] SatLow  = -66'sh0_8000_0000;

    word_t matrix_q16 [16];
    quad_t expected_vertices [$];
    int mismatches;

    function new();
      foreach (matrix_q16[i]) matrix_q16[i] = '0;
      mismatches = 0;
    endfunction

    function word_t row_dot(int row, quad_t vec);
      logic signed [65:0] acc;
      logic signed [65:0] a;
      logic signed [65:0] b;
      acc = '0;
      for (int c = 0; c < Dim; c++) begin
        a = $signed(matrix_q16[row * 4 + c]);
        b = $signed(vec[c]);
        acc = acc + a * b;
      end
      acc = acc >>> FracBits;
      if (acc > SatHigh) return 32'h7FFF_FFFF;
      if (acc < SatLow) return 32'h8000_0000;
      return acc[31:0];
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    function void note_beat(logic op, logic [1:0] row, logic [1:0] col, word_t value,
                            quad_t vec);
      quad_t vertex;
      if (op == OP_WRITE) begin
        matrix_q16[{row, col}] = value;
      end else begin
        for (int r = 0; r < Dim; r++) vertex[r] = row_dot(r, vec);
        expected_vertices.push_back(vertex);
      end
    endfunction

    task check_beat(quad_t got);
      quad_t want;
      string lanes [4] = '{"out_x", "out_y", "out_z", "out_w"};
      if (expected_vertices.size() == 0) begin
        report("output beat with no transform pending");
        return;
      end
      want = expected_vertices.pop_front();
      for (int i = 0; i < Dim; i++) begin
        if (got[i] !== want[i]) begin
          report($sformatf("%s got %h want %h", lanes[i], got[i], want[i]));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_WRITE;
  logic [1:0] elem_row = '0;
  logic [1:0] elem_col = '0;
  logic signed [31:0] elem_value = '0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic signed [31:0] vec_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;

  bit quiet_tail = 1'b0;
  int stall_cycles = 0;
  vertex_scoreboard sb = new();

  homogeneous_vertex_transform_core #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .elem_row(elem_row),
    .elem_col(elem_col),
    .elem_value(elem_value),
    .vec_x(vec_x),
    .vec_y(vec_y),
    .vec_z(vec_z),
    .vec_w(vec_w),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_w(out_w)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic quad_t vec4(word_t x, word_t y, word_t z, word_t w);
    return {w, z, y, x};
  endfunction

  function automatic word_t rand_q16();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return QMax;
      2: return QMin;
      3: return '0;
      4: return $urandom_range(0, 1) ? QOne : -QOne;
      default: return word_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic quad_t rand_vec();
    return vec4(rand_q16(), rand_q16(), rand_q16(), rand_q16());
  endfunction

  function automatic quad_t noise_vec();
    return vec4($urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  task automatic send_beat(logic op, logic [1:0] row, logic [1:0] col, word_t value,
                           quad_t vec);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    elem_row   <= row;
    elem_col   <= col;
    elem_value <= value;
    vec_x      <= vec[0];
    vec_y      <= vec[1];
    vec_z      <= vec[2];
    vec_w      <= vec[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_elem(logic [1:0] row, logic [1:0] col, word_t value);
    send_beat(OP_WRITE, row, col, value, noise_vec());
  endtask

  task automatic transform_vec(quad_t vec);
    send_beat(OP_TRANSFORM, 2'($urandom()), 2'($urandom()), $urandom(), vec);
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_beat(opcode, elem_row, elem_col, elem_value, {vec_w, vec_z, vec_y, vec_x});
      end
      if (out_valid && out_ready) begin
        sb.check_beat({out_w, out_z, out_y, out_x});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int items;
    int n_writes;
    int n_xf;
    int sel;
    logic [3:0] idx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    transform_vec(vec4(QMax, QMin, QNeg1, QOne));
    for (int i = 0; i < Dim; i++) write_elem(2'(i), 2'(i), QOne);
    transform_vec(vec4(32'h0001_8000, 32'hFFFD_C000, QMin, QMax));
    write_elem(2'd0, 2'd1, QMax);
    write_elem(2'd0, 2'd0, QMax);
    transform_vec(vec4(QMax, QMax, '0, '0));
    write_elem(2'd1, 2'd0, QMin);
    transform_vec(vec4(QMax, '0, '0, '0));
    write_elem(2'd2, 2'd2, 32'd1);
    transform_vec(vec4('0, '0, QNeg1, '0));
    transform_vec(vec4('0, '0, 32'd1, '0));
    write_elem(2'd3, 2'd3, QMin);
    transform_vec(vec4('0, '0, '0, QMin));
    write_elem(2'd3, 2'd2, QMax);
    transform_vec(vec4('0, '0, QMax, QMax));
    for (int c = 0; c < Dim; c++) write_elem(2'd2, 2'(c), QMin);
    transform_vec(vec4(QMin, QMin, QMin, QMin));

    items = 0;
    while (items < RandomItems) begin
      if (items >= RandomItems - QuietItems) quiet_tail = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        n_xf = $urandom_range(1, 6);
        for (int i = 0; i < n_xf; i++) begin
          send_beat(1'($urandom()), 2'($urandom()), 2'($urandom()), $urandom(), noise_vec());
        end
        items += n_xf;
      end else begin
        n_writes = (sel < 3) ? 16 : $urandom_range(0, 4);
        for (int i = 0; i < n_writes; i++) begin
          idx = (n_writes == 16) ? 4'(i) : 4'($urandom());
          write_elem(idx[3:2], idx[1:0], rand_q16());
        end
        n_xf = $urandom_range(1, 8);
        for (int i = 0; i < n_xf; i++) transform_vec(rand_vec());
        items += n_writes + n_xf;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_vertices.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hvt_pkg.sv
hdl/hvt_lane.sv
hdl/homogeneous_vertex_transform_core.sv
test/testbench.sv
